FILE: rtl/core/drc_pkg.sv
// Shared types and constants for the DDA column raycast core.
// No dependencies; imported by dda_raycast_column_core (drc_divider does not use it).
`timescale 1ns / 1ps

package drc_pkg;

  // Fixed-point fraction bits of positions, directions and distances
  localparam int unsigned FRAC_BITS = 16;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 21;

  // Input item kinds carried on tuser
  localparam logic OP_WRITE_CELL = 1'b0;
  localparam logic OP_CAST       = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 3'd7;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_MULX,
    ST_MULY,
    ST_RAYY,
    ST_DIVX,
    ST_DIVY,
    ST_SIDEX,
    ST_SIDEY,
    ST_SIDEF,
    ST_STEP,
    ST_LOOK,
    ST_HEIGHT,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/core/dda_raycast_column_core.sv
// Top level of the DDA column raycaster: map memory, sequencer, shared multiplier.
// Depends on drc_pkg and drc_divider.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: cell fields and column, tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: column, slice rows, hit_side
// cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// After reset a clearing pass zeroes all DEPTH map cells (1024 by default), one cell a
// cycle; no item is taken meanwhile, configuration writes are.
// A cell write is stored in the map memory from ST_IDLE. A cast runs four divisions in
// the shared divider (camera, two reciprocals, line height), plus accept, multiply, setup
// and output states, and an ST_STEP/ST_LOOK pair per DDA step for the map read.
// A finished result waits in the output register; a new item is taken meanwhile, and
// a cast holds in its last state while the previous result is still waiting.

module dda_raycast_column_core #(
  parameter int unsigned MAP_SIZE  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] column, [16:12] cell_row, [21:17] cell_col, [29:22] cell_value
  input  logic [drc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] out_column, [23:12] first wall row, [35:24] last wall row, [36] hit_side
  output logic [drc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [drc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import drc_pkg::*;

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned IW    = $clog2(MAP_SIZE);
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CAMW  = 14 + F;
  localparam int unsigned RW    = 33;
  localparam int unsigned DW    = F + 15;
  localparam int unsigned SW    = F + 23;
  localparam int unsigned CW    = 23 - F;
  localparam int unsigned LHW   = 12 + F;
  localparam int unsigned MA    = (F + 2 > 18) ? F + 2 : 18;
  localparam int unsigned MB    = F + 16;
  localparam int unsigned PW    = MA + MB;
  localparam int unsigned NW    = (2 * F + 1 > 13 + F) ? 2 * F + 1 : 13 + F;
  localparam int unsigned DDW   = (SW > RW) ? SW : RW;

  // Configuration registers
  logic [20:0]        pos_x_q, pos_y_q;
  logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [11:0]        scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 21'd1441792;
      pos_y_q   <= 21'd786432;
      dir_x_q   <= -18'sd65536;
      dir_y_q   <= 18'sd0;
      plane_x_q <= 18'sd0;
      plane_y_q <= 18'sd43254;
      scr_w_q   <= 12'd800;
      scr_h_q   <= 12'd600;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POS_X:    pos_x_q   <= cfg_data_i;
        CFG_POS_Y:    pos_y_q   <= cfg_data_i;
        CFG_DIR_X:    dir_x_q   <= cfg_data_i[17:0];
        CFG_DIR_Y:    dir_y_q   <= cfg_data_i[17:0];
        CFG_PLANE_X:  plane_x_q <= cfg_data_i[17:0];
        CFG_PLANE_Y:  plane_y_q <= cfg_data_i[17:0];
        CFG_SCREEN_W: scr_w_q   <= cfg_data_i[11:0];
        CFG_SCREEN_H: scr_h_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [11:0] in_column;
  logic [4:0]  in_row, in_col;
  logic [7:0]  in_value;
  assign in_column = s_axis_tdata[11:0];
  assign in_row    = s_axis_tdata[16:12];
  assign in_col    = s_axis_tdata[21:17];
  assign in_value  = s_axis_tdata[29:22];

  state_e state_q, state_d;
  logic   in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Datapath registers
  logic [AW-1:0]          clr_q;
  logic [11:0]            column_q;
  logic signed [CAMW-1:0] cam_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [RW-1:0]   rx_q, ry_q;
  logic [DW-1:0]          dx_q, dy_q;
  logic [SW-1:0]          sx_q, sy_q;
  logic signed [CW-1:0]   cx_q, cy_q;
  logic                   side_q;
  logic                   pzero_q;
  logic [11:0]            ds_q, de_q;
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // Shared divider
  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DDW-1:0]  div_den;
  logic            div_done;
  logic [NW-1:0]   div_quo;

  drc_divider #(
    .NW(NW),
    .DW(DDW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Derived values
  logic [11:0]          w_eff;
  logic [RW-1:0]        absx, absy;
  logic [DW-1:0]        delta;
  logic                 delta_zero;
  logic [F:0]           fracx, fracy;
  logic [SW-1:0]        perp;
  logic                 lt;
  logic signed [CW-1:0] cx_n, cy_n;
  logic                 wall;
  logic [7:0]           cell_q;
  logic [LHW-1:0]       lh, lhh, de_sum;
  logic [11:0]          hh;

  assign w_eff = (scr_w_q == 12'd0) ? 12'd1 : scr_w_q;
  assign absx  = rx_q[RW-1] ? -rx_q : rx_q;
  assign absy  = ry_q[RW-1] ? -ry_q : ry_q;
  assign fracx = rx_q[RW-1] ? {1'b0, pos_x_q[F-1:0]}
                            : (F+1)'(1 << F) - {1'b0, pos_x_q[F-1:0]};
  assign fracy = ry_q[RW-1] ? {1'b0, pos_y_q[F-1:0]}
                            : (F+1)'(1 << F) - {1'b0, pos_y_q[F-1:0]};

  // Saturate the reciprocal; a zero component gives the largest value
  assign delta_zero = (state_q == ST_DIVX) ? (rx_q == '0) : (ry_q == '0);
  assign delta = (delta_zero ||
                  ({{DW{1'b0}}, div_quo} > {{NW{1'b0}}, {DW{1'b1}}}))
                 ? {DW{1'b1}} : DW'(div_quo);

  // DDA step: the one compare picks the axis
  assign lt = sx_q < sy_q;
  assign cx_n = lt ? (rx_q[RW-1] ? cx_q - CW'(1) : cx_q + CW'(1)) : cx_q;
  assign cy_n = lt ? cy_q : (ry_q[RW-1] ? cy_q - CW'(1) : cy_q + CW'(1));

  assign wall = (cx_q < 0) || (cy_q < 0) ||
                (cx_q >= $signed(CW'(MAP_SIZE))) || (cy_q >= $signed(CW'(MAP_SIZE))) ||
                (cell_q != 8'd0);
  assign perp = side_q ? sy_q - SW'(dy_q) : sx_q - SW'(dx_q);

  // Slice bounds from line height
  assign lh     = pzero_q ? {scr_h_q, {F{1'b0}}} : div_quo[LHW-1:0];
  assign lhh    = lh >> 1;
  assign hh     = {1'b0, scr_h_q[11:1]};
  assign de_sum = LHW'(hh) + lhh;

  // Map memory
  logic [7:0]    map_mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      cell_q <= map_mem[mem_ra];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc && s_axis_tuser == OP_CAST) state_d = ST_CAM;
      ST_CAM:    if (div_done) state_d = ST_MULX;
      ST_MULX:   state_d = ST_MULY;
      ST_MULY:   state_d = ST_RAYY;
      ST_RAYY:   state_d = ST_DIVX;
      ST_DIVX:   if (div_done) state_d = ST_DIVY;
      ST_DIVY:   if (div_done) state_d = ST_SIDEX;
      ST_SIDEX:  state_d = ST_SIDEY;
      ST_SIDEY:  state_d = ST_SIDEF;
      ST_SIDEF:  state_d = ST_STEP;
      ST_STEP:   state_d = ST_LOOK;
      ST_LOOK:   state_d = wall ? ST_HEIGHT : ST_STEP;
      ST_HEIGHT: if (div_done) state_d = ST_OUT;
      ST_OUT:    if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider, memory and multiplier operands
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mem_we    = 1'b0;
    mem_wa    = clr_q;
    mem_wd    = 8'd0;
    mem_re    = 1'b0;
    mem_ra    = {cx_n[IW-1:0], cy_n[IW-1:0]};
    mul_a     = MA'(plane_x_q);
    mul_b     = MB'(cam_q);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (in_acc && s_axis_tuser == OP_CAST) begin
          div_start = 1'b1;
          div_num   = NW'({in_column, {(F+1){1'b0}}});
          div_den   = DDW'(w_eff);
        end else if (in_acc) begin
          mem_we = (32'(in_row) < MAP_SIZE) && (32'(in_col) < MAP_SIZE);
          mem_wa = {in_row[IW-1:0], in_col[IW-1:0]};
          mem_wd = in_value;
        end
      end
      ST_MULY: begin
        mul_a = MA'(plane_y_q);
      end
      ST_RAYY: begin
        div_start = 1'b1;
        div_num   = NW'(1) << (2 * F);
        div_den   = DDW'(absx);
      end
      ST_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NW'(1) << (2 * F);
          div_den   = DDW'(absy);
        end
      end
      ST_SIDEX: begin
        mul_a = $signed(MA'(fracx));
        mul_b = $signed(MB'(dx_q));
      end
      ST_SIDEY: begin
        mul_a = $signed(MA'(fracy));
        mul_b = $signed(MB'(dy_q));
      end
      ST_STEP: begin
        mem_re = 1'b1;
      end
      ST_LOOK: begin
        if (wall) begin
          div_start = 1'b1;
          div_num   = NW'({scr_h_q, {F{1'b0}}});
          div_den   = DDW'(perp);
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_OUT && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath: advance per sequencer state
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE:  column_q <= in_column;
      ST_CAM:   cam_q <= $signed(CAMW'(div_quo)) - $signed(CAMW'(1 << F));
      ST_MULY:  rx_q <= RW'(dir_x_q) + RW'(prod_q >>> F);
      ST_RAYY:  ry_q <= RW'(dir_y_q) + RW'(prod_q >>> F);
      ST_DIVX:  if (div_done) dx_q <= delta;
      ST_DIVY:  if (div_done) dy_q <= delta;
      ST_SIDEY: sx_q <= SW'(prod_q[PW-1:F]);
      ST_SIDEF: begin
        sy_q <= SW'(prod_q[PW-1:F]);
        cx_q <= $signed({2'b00, pos_x_q[20:F]});
        cy_q <= $signed({2'b00, pos_y_q[20:F]});
      end
      ST_STEP: begin
        if (lt) begin
          sx_q   <= sx_q + SW'(dx_q);
          side_q <= 1'b0;
        end else begin
          sy_q   <= sy_q + SW'(dy_q);
          side_q <= 1'b1;
        end
        cx_q <= cx_n;
        cy_q <= cy_n;
      end
      ST_LOOK:  pzero_q <= (perp == '0);
      ST_HEIGHT: begin
        if (div_done) begin
          ds_q <= (lhh >= LHW'(hh)) ? 12'd0 : hh - lhh[11:0];
          if (scr_h_q == 12'd0) begin
            de_q <= 12'd0;
          end else if (de_sum >= LHW'(scr_h_q)) begin
            de_q <= scr_h_q - 12'd1;
          end else begin
            de_q <= de_sum[11:0];
          end
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_data_q <= {3'b000, side_q, de_q, ds_q, column_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/core/drc_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the raycast core for all divisions.
`timescale 1ns / 1ps

module drc_divider #(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 39
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [DW:0]     rem_q, rem_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;

  // One trial subtraction per cycle
  always_comb begin
    trial  = {rem_q[DW-1:0], quo_q[NW-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
